// File: design/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path segment densifier package
// Shared payload types, the controller command and status bundles and the
// widths that follow from the fixed field formats.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned StepW  = 31;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned SqW    = 66;
  localparam int unsigned CntW   = 7;
  localparam int unsigned QW     = 40;

  typedef struct packed {
    logic signed [CoordW-1:0] way_x;
    logic signed [CoordW-1:0] way_y;
    logic                     path_start;
  } req_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pt_x;
    logic signed [CoordW-1:0] pt_y;
    logic                     run_last;
    logic                     capped;
  } req_out_t;

  typedef struct packed {
    logic load;
    logic sq_x;
    logic sq_y;
    logic cnt_init;
    logic cnt_step;
    logic pt_init;
    logic div_init;
    logic div_step;
    logic div_sel_y;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic zero;
    logic reach_ok;
    logic cnt_max;
    logic div_done;
    logic pt_last;
  } sts_t;

endpackage
`default_nettype wire

// File: design/path_segment_densifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path segment densifier
// Resamples a stream of Q16.16 waypoints into evenly spaced path points.
// ----------------------------------------------------------------------------
// Channel  Signals                    Payload
// in       in_valid_i / in_stall_o    psd_pkg::req_in_t
// out      out_valid_o / out_stall_i  psd_pkg::req_out_t
// cfg      cfg_we_i / cfg_wdata_i     step size, 31 bits
//
// A first waypoint is sent out as a single point; a repeated one gives no output.
// Otherwise a count search finds the number of points, then each point takes
// two 40-step restoring divisions plus the handshake.
// Reset clears the previous waypoint and sets the step size to 6554.
// A stalled output holds the block; no input is taken until all points leave.
// ----------------------------------------------------------------------------
module path_segment_densifier #(
  parameter int unsigned MaxSteps = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire psd_pkg::req_in_t          in_req_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output psd_pkg::req_out_t              out_req_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [psd_pkg::StepW-1:0] cfg_wdata_i
);

  logic [psd_pkg::StepW-1:0] step_q;
  psd_pkg::cmd_t cmd;
  psd_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= psd_pkg::StepW'(6554);
    else if (cfg_we_i) step_q <= cfg_wdata_i;
  end

  psd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  psd_datapath #(.MaxSteps(MaxSteps)) u_dp (
    .clk_i, .rst_ni, .in_i(in_req_i), .step_i(step_q),
    .cmd_i(cmd), .sts_o(sts), .out_o(out_req_o)
  );

endmodule
`default_nettype wire

// File: design/psd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path segment densifier datapath
// Holds the previous waypoint, finds the point count by squared compare and
// interpolates each point with a shared restoring divider.
// ----------------------------------------------------------------------------
module psd_datapath #(
  parameter int unsigned MaxSteps = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire psd_pkg::req_in_t           in_i,
  input  wire logic [psd_pkg::StepW-1:0]  step_i,
  input  wire psd_pkg::cmd_t              cmd_i,
  output psd_pkg::sts_t                   sts_o,
  output psd_pkg::req_out_t               out_o
);

  localparam int unsigned CW = psd_pkg::CntW;
  localparam int unsigned QW = psd_pkg::QW;
  localparam int unsigned DivCnt = 6;
  localparam int unsigned RW = 77;

  logic signed [psd_pkg::CoordW-1:0] prev_x_q, prev_y_q, base_x_q, base_y_q;
  logic have_prev_q;
  logic signed [psd_pkg::DiffW-1:0] dx_q, dy_q;
  logic [psd_pkg::SqW:0] dist2_q;
  logic [psd_pkg::DiffW-1:0] mag_sel;
  logic [psd_pkg::SqW-1:0] sq_prod;
  logic [CW-1:0] cnt_q, pt_q;
  logic [2*psd_pkg::StepW-1:0] step_sq;
  logic [RW-1:0] reach2_q, inc_q;
  logic [QW-1:0] num_q, quo_q;
  logic [QW:0] rem_q, rem_try;
  logic [DivCnt-1:0] div_cnt_q;
  logic signed [psd_pkg::CoordW-1:0] res_x_q;
  logic capped_q;
  logic [QW-1:0] num_init;
  logic [psd_pkg::DiffW-1:0] mag_div;
  logic [CW:0] den2;
  logic [psd_pkg::CoordW-1:0] q32;
  logic pt_end;

  assign mag_sel = cmd_i.sq_y ? (dy_q[psd_pkg::DiffW-1] ? -dy_q : dy_q)
                              : (dx_q[psd_pkg::DiffW-1] ? -dx_q : dx_q);
  assign sq_prod = mag_sel * mag_sel;
  // The squared reach grows by (2n + 1) * step^2 from one count to the next.
  assign step_sq = step_i * step_i;
  assign mag_div = cmd_i.div_sel_y ? (dy_q[psd_pkg::DiffW-1] ? -dy_q : dy_q)
                                   : (dx_q[psd_pkg::DiffW-1] ? -dx_q : dx_q);
  // Numerator 2*|d|*i + n, divided by 2*n.
  assign num_init = QW'({mag_div, 1'b0}) * QW'(pt_q) + QW'(cnt_q);
  assign den2 = {cnt_q, 1'b0};
  assign rem_try = {rem_q[QW-1:0], num_q[QW-1]} - (QW+1)'(den2);
  assign q32 = quo_q[psd_pkg::CoordW-1:0];
  assign pt_end = pt_q == cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      have_prev_q <= 1'b0;
    end else if (cmd_i.load) begin
      prev_x_q <= in_i.way_x;
      prev_y_q <= in_i.way_y;
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_x_q <= prev_x_q;
      base_y_q <= prev_y_q;
      dx_q <= psd_pkg::DiffW'(in_i.way_x) - psd_pkg::DiffW'(prev_x_q);
      dy_q <= psd_pkg::DiffW'(in_i.way_y) - psd_pkg::DiffW'(prev_y_q);
      out_o.pt_y <= in_i.way_y;
      out_o.pt_x <= in_i.way_x;
      out_o.capped <= 1'b0;
      capped_q <= 1'b0;
    end
    if (cmd_i.sq_x) dist2_q <= (psd_pkg::SqW+1)'(sq_prod);
    if (cmd_i.sq_y) dist2_q <= dist2_q + (psd_pkg::SqW+1)'(sq_prod);
    if (cmd_i.cnt_init) begin
      cnt_q <= CW'(1);
      reach2_q <= RW'(step_sq);
      inc_q <= RW'({step_sq, 1'b0}) + RW'(step_sq);
    end
    if (cmd_i.cnt_step) begin
      if (sts_o.cnt_max) capped_q <= 1'b1;
      else begin
        cnt_q <= cnt_q + CW'(1);
        reach2_q <= reach2_q + inc_q;
        inc_q <= inc_q + RW'({step_sq, 1'b0});
      end
    end
    if (cmd_i.pt_init) pt_q <= CW'(1);
    if (cmd_i.div_init) begin
      num_q <= num_init;
      rem_q <= '0;
      quo_q <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[QW-2:0], 1'b0};
      div_cnt_q <= div_cnt_q + DivCnt'(1);
      if (!rem_try[QW]) begin
        rem_q <= rem_try;
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[QW-1:0], num_q[QW-1]};
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
    if (sts_o.div_done && !cmd_i.div_step && !cmd_i.div_init && !cmd_i.emit) begin
      if (!cmd_i.div_sel_y)
        res_x_q <= dx_q[psd_pkg::DiffW-1] ? base_x_q - q32 : base_x_q + q32;
      else
        out_o.pt_y <= dy_q[psd_pkg::DiffW-1] ? base_y_q - q32 : base_y_q + q32;
    end
    if (cmd_i.emit) begin
      out_o.pt_x <= res_x_q;
      out_o.run_last <= pt_end;
      out_o.capped <= capped_q;
      pt_q <= pt_q + CW'(1);
    end
    if (cmd_i.load) out_o.run_last <= 1'b1;
  end

  assign sts_o.first = in_i.path_start || !have_prev_q;
  assign sts_o.zero = (dx_q == '0) && (dy_q == '0);
  assign sts_o.reach_ok = reach2_q >= RW'(dist2_q);
  assign sts_o.cnt_max = cnt_q >= CW'(MaxSteps);
  assign sts_o.div_done = div_cnt_q == DivCnt'(QW);
  assign sts_o.pt_last = out_o.run_last;

endmodule
`default_nettype wire

// File: design/psd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path segment densifier controller
// Sequences load, count search, per-point division and output handshake.
// ----------------------------------------------------------------------------
module psd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire psd_pkg::sts_t sts_i,
  output psd_pkg::cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StSqX   = 10'b0000000010,
    StSqY   = 10'b0000000100,
    StCount = 10'b0000001000,
    StDivX  = 10'b0000010000,
    StFixX  = 10'b0000100000,
    StDivY  = 10'b0001000000,
    StFixY  = 10'b0010000000,
    StOut   = 10'b0100000000,
    StFirst = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut) || (state_q == StFirst);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.div_sel_y = (state_q == StDivY) || (state_q == StFixY);
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = sts_i.first ? StFirst : StSqX;
        end
      end
      StSqX: begin
        if (sts_i.zero) state_d = StIdle;
        else begin
          cmd_o.sq_x = 1'b1;
          state_d = StSqY;
        end
      end
      StSqY: begin
        cmd_o.sq_y = 1'b1;
        cmd_o.cnt_init = 1'b1;
        cmd_o.pt_init = 1'b1;
        state_d = StCount;
      end
      StCount: begin
        if (sts_i.reach_ok) begin
          cmd_o.div_init = 1'b1;
          state_d = StDivX;
        end else begin
          cmd_o.cnt_step = 1'b1;
          if (sts_i.cnt_max) begin
            cmd_o.div_init = 1'b1;
            state_d = StDivX;
          end
        end
      end
      StDivX: begin
        if (sts_i.div_done) state_d = StFixX;
        else cmd_o.div_step = 1'b1;
      end
      StFixX: begin
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d = StDivY;
      end
      StDivY: begin
        if (sts_i.div_done) state_d = StFixY;
        else cmd_o.div_step = 1'b1;
      end
      StFixY: begin
        cmd_o.emit = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) begin
          if (sts_i.pt_last) state_d = StIdle;
          else begin
            cmd_o.div_init = 1'b1;
            state_d = StDivX;
          end
        end
      end
      StFirst: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !accept) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");

endmodule
`default_nettype wire
